FILE: sv/sdr_pkg.sv
// Package for the signed divide/remainder core.
// Holds the default data width shared by the core, its interfaces and its checker.
// No dependencies.
package sdr_pkg;

	localparam int DATA_WIDTH_DEF = 32;

endpackage : sdr_pkg

FILE: sv/sdr_req_if.sv
// Request channel of the signed divide/remainder core: dividend and divisor.
// Depends on sdr_pkg for the default data width.
interface sdr_req_if
	import sdr_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);

	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] dividend;
	logic signed [DATA_WIDTH-1:0] divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink   (input valid, input dividend, input divisor, output ready);

endinterface : sdr_req_if

FILE: sv/sdr_rsp_if.sv
// Response channel of the signed divide/remainder core: quotient, remainder, zero flag.
// Depends on sdr_pkg for the default data width.
interface sdr_rsp_if
	import sdr_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);

	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] quotient;
	logic signed [DATA_WIDTH-1:0] remainder;
	logic                         div_by_zero;

	modport source (output valid, output quotient, output remainder, output div_by_zero,
		input ready);
	modport sink   (input valid, input quotient, input remainder, input div_by_zero,
		output ready);

endinterface : sdr_rsp_if

FILE: sv/signed_divide_remainder_core.sv
// Signed integer divider with remainder, radix-2 restoring, one quotient bit per cycle.
// Depends on sdr_pkg, sdr_req_if and sdr_rsp_if.
//
// Usage:
//   req carries a signed dividend and divisor under valid/ready; a request is taken
//   when both are high. rsp returns the quotient (truncated toward zero), the
//   remainder (sign of the dividend) and div_by_zero under valid/ready.
//   A zero divisor sets div_by_zero with zero quotient and remainder. The most
//   negative value over minus one returns the most negative value, remainder zero.
// Timing:
//   One request at a time. req.ready is high only while the sequencer is idle.
//   Magnitudes are taken at acceptance, then DATA_WIDTH passes run through the
//   shared shift-subtract unit, and signs are applied as the result is loaded into
//   the output register. A zero divisor skips the passes. The next request is taken
//   the cycle after the result reaches the output register, so a new request cannot
//   be taken before the previous one is through.
// Stall and reset:
//   The result sits in an output register until rsp.ready; a finished division
//   waits in its sign stage while an earlier result is still held there.
//   arst_n clears the sequencer and rsp.valid; req.ready is high in reset but no division starts.
module signed_divide_remainder_core
	import sdr_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
)(
	input  logic       clk,
	input  logic       arst_n,
	sdr_req_if.sink    req,
	sdr_rsp_if.source  rsp
);

	localparam int CNT_W = $clog2(DATA_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_RUN    = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] den_q;
	logic                  q_neg_q;
	logic                  r_neg_q;
	logic                  dz_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] quo_out_q;
	logic [DATA_WIDTH-1:0] rem_out_q;
	logic                  dz_out_q;

	logic [DATA_WIDTH-1:0] a_u;
	logic [DATA_WIDTH-1:0] b_u;
	logic                  a_neg;
	logic                  b_neg;
	logic [DATA_WIDTH-1:0] mag_a;
	logic [DATA_WIDTH-1:0] mag_b;
	logic                  b_zero;
	logic                  take;
	logic [DATA_WIDTH:0]   shifted;
	logic [DATA_WIDTH-1:0] diff;
	logic                  ge;
	logic                  out_free;
	logic                  load_out;

	assign a_u    = req.dividend;
	assign b_u    = req.divisor;
	assign a_neg  = a_u[DATA_WIDTH-1];
	assign b_neg  = b_u[DATA_WIDTH-1];
	assign mag_a  = a_neg ? (DATA_WIDTH'(0) - a_u) : a_u;
	assign mag_b  = b_neg ? (DATA_WIDTH'(0) - b_u) : b_u;
	assign b_zero = (b_u == '0);

	assign req.ready = (state_q == ST_IDLE);
	assign take      = req.valid && (state_q == ST_IDLE);

	// shared shift-subtract unit
	assign shifted = {rem_q, acc_q[DATA_WIDTH-1]};
	assign diff    = shifted[DATA_WIDTH-1:0] - den_q;
	assign ge      = (shifted >= {1'b0, den_q});

	assign out_free = !out_valid_q || rsp.ready;
	assign load_out = (state_q == ST_FINISH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && !rsp.ready);
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cnt_q   <= CNT_W'(DATA_WIDTH - 1);
						state_q <= b_zero ? ST_FINISH : ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			acc_q   <= b_zero ? '0 : mag_a;
			den_q   <= mag_b;
			rem_q   <= '0;
			q_neg_q <= a_neg ^ b_neg;
			r_neg_q <= a_neg;
			dz_q    <= b_zero;
		end else if (state_q == ST_RUN) begin
			acc_q <= {acc_q[DATA_WIDTH-2:0], ge};
			rem_q <= ge ? diff : shifted[DATA_WIDTH-1:0];
		end
		if (load_out) begin
			quo_out_q <= q_neg_q ? (DATA_WIDTH'(0) - acc_q) : acc_q;
			rem_out_q <= r_neg_q ? (DATA_WIDTH'(0) - rem_q) : rem_q;
			dz_out_q  <= dz_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.quotient    = quo_out_q;
	assign rsp.remainder   = rem_out_q;
	assign rsp.div_by_zero = dz_out_q;

endmodule : signed_divide_remainder_core

FILE: sv/sdr_checker.sv
// Port checker for the signed divide/remainder core, bound to the core module.
// Depends on sdr_pkg and signed_divide_remainder_core.
module sdr_checker
	import sdr_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
)(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic [DATA_WIDTH-1:0] quotient,
	input logic [DATA_WIDTH-1:0] remainder,
	input logic                  div_by_zero
);

	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(quotient) && $stable(remainder)
			&& $stable(div_by_zero))
		else $error("stalled response changed");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && div_by_zero |-> (quotient == '0) && (remainder == '0))
		else $error("zero divisor gave non-zero result");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a division is in flight");

endmodule : sdr_checker

bind signed_divide_remainder_core sdr_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_sdr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.quotient    (rsp.quotient),
	.remainder   (rsp.remainder),
	.div_by_zero (rsp.div_by_zero)
);
